// ===== design/qvr_pkg.sv =====
package qvr_pkg;

    localparam int FRAC_BITS  = 14;
    localparam int VEC_W      = 16;
    localparam int Q_W        = 16;
    localparam int ROT_W      = 17;

    // sum of squares and its square root
    localparam int SUM_W      = 2 * VEC_W;
    localparam int SQ_PAD     = 16;
    localparam int RAD_W      = SUM_W + SQ_PAD;
    localparam int RES_W      = RAD_W + 1;
    localparam int ROOT_W     = RAD_W / 2;
    localparam int SQ_N       = ROOT_W;

    // per-component divide
    localparam int LEN_FRAC   = SQ_PAD / 2;
    localparam int QUO_W      = FRAC_BITS + 1;
    localparam int REM_W      = VEC_W + FRAC_BITS + LEN_FRAC + 1;
    localparam int UNIT_W     = QUO_W + 1;

    // Hamilton products
    localparam int PR_W       = Q_W + UNIT_W;
    localparam int PS_W       = PR_W + 2;
    localparam int P_W        = PS_W - FRAC_BITS;
    localparam int MR_W       = P_W + Q_W;
    localparam int R_W        = MR_W + 2;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam int ADDR_W     = 4;
    localparam int DATA_W     = 32;

    typedef enum logic [1:0] {
        REG_QUAT_W = 2'd0,
        REG_QUAT_X = 2'd1,
        REG_QUAT_Y = 2'd2,
        REG_QUAT_Z = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic signed [Q_W-1:0] w;
        logic signed [Q_W-1:0] x;
        logic signed [Q_W-1:0] y;
        logic signed [Q_W-1:0] z;
    } t_quat;

    typedef struct packed {
        logic [VEC_W-1:0] mag_x;
        logic [VEC_W-1:0] mag_y;
        logic [VEC_W-1:0] mag_z;
        logic [2:0]       neg;
        logic             zero;
        logic [SUM_W-1:0] sumsq;
    } t_item;

    typedef struct packed {
        logic full;
        logic empty;
    } t_fifo_stat;

endpackage

// ===== design/qvr_if.sv =====
interface qvr_in_if import qvr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [VEC_W-1:0] vec_x;
    logic signed [VEC_W-1:0] vec_y;
    logic signed [VEC_W-1:0] vec_z;

    modport source (output valid, vec_x, vec_y, vec_z, input ready);
    modport sink   (input valid, vec_x, vec_y, vec_z, output ready);
endinterface

interface qvr_out_if import qvr_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic signed [ROT_W-1:0] rot_x;
    logic signed [ROT_W-1:0] rot_y;
    logic signed [ROT_W-1:0] rot_z;
    logic                    zero_input;

    modport source (output valid, rot_x, rot_y, rot_z, zero_input, input ready);
    modport sink   (input valid, rot_x, rot_y, rot_z, zero_input, output ready);
endinterface

// ===== design/quaternion_vector_rotation.sv =====
// Rotates a stream of 3D vectors by a configured quaternion.
// Input channel i_in carries vec_x/vec_y/vec_z beats (16-bit signed, any
// common scale); output channel o_out carries rot_x/rot_y/rot_z (Q2.14,
// saturated) and zero_input, one result beat per input beat, in order.
// Each vector is normalized (pipelined square root, then a pipelined
// restoring divide per component) and rotated as q*(0,u)*conj(q).
// The quaternion sits in four APB registers at 0x0 (w), 0x4 (x), 0x8 (y),
// 0xC (z), Q1.14 signed in bits 15:0; write them only while no beat is in
// flight.
// Throughput: one beat per cycle while o_out.ready stays high. The pipeline
// is made up of the 24-stage square root, the 15-stage divide and four
// multiply stages.
// An input register feeds a 4-entry queue ahead of the arithmetic pipeline,
// so input stays ready while the queue has room. When the receiver holds
// o_out.ready low, the pipeline freezes, the queue fills and i_in.ready
// drops. Reset (synchronous, active low) empties queue and pipeline and
// sets the quaternion to identity.
module quaternion_vector_rotation import qvr_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    qvr_in_if.sink            i_in,
    qvr_out_if.source         o_out,
    input  logic              i_psel,
    input  logic              i_penable,
    input  logic              i_pwrite,
    input  logic [ADDR_W-1:0] i_paddr,
    input  logic [DATA_W-1:0] i_pwdata,
    output logic [DATA_W-1:0] o_prdata,
    output logic              o_pready
);

    t_quat      r_quat;
    t_item      front_item;
    t_item      fifo_item;
    t_fifo_stat fifo_stat;
    logic       push;
    logic       pop;
    t_reg_idx   reg_idx;
    logic       wr;

    assign reg_idx  = t_reg_idx'(i_paddr[ADDR_W-1:2]);
    assign wr       = i_psel && i_penable && i_pwrite;
    assign o_pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_quat.w <= Q_W'(2**FRAC_BITS);
            r_quat.x <= '0;
            r_quat.y <= '0;
            r_quat.z <= '0;
        end else if (wr) begin
            case (reg_idx)
                REG_QUAT_W: r_quat.w <= i_pwdata[Q_W-1:0];
                REG_QUAT_X: r_quat.x <= i_pwdata[Q_W-1:0];
                REG_QUAT_Y: r_quat.y <= i_pwdata[Q_W-1:0];
                REG_QUAT_Z: r_quat.z <= i_pwdata[Q_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_QUAT_W: o_prdata = DATA_W'(r_quat.w);
            REG_QUAT_X: o_prdata = DATA_W'(r_quat.x);
            REG_QUAT_Y: o_prdata = DATA_W'(r_quat.y);
            REG_QUAT_Z: o_prdata = DATA_W'(r_quat.z);
            default:    o_prdata = '0;
        endcase
    end

    qvr_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (i_in),
        .i_stat  (fifo_stat),
        .o_push  (push),
        .o_item  (front_item)
    );

    qvr_fifo u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (fifo_item),
        .o_stat  (fifo_stat)
    );

    qvr_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_quat  (r_quat),
        .i_item  (fifo_item),
        .i_stat  (fifo_stat),
        .o_pop   (pop),
        .o_out   (o_out)
    );

endmodule

// ===== design/qvr_front.sv =====
module qvr_front import qvr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    qvr_in_if.sink     i_in,
    input  t_fifo_stat i_stat,
    output logic       o_push,
    output t_item      o_item
);

    logic  r_valid;
    t_item r_item;
    t_item n_item;

    assign i_in.ready = !r_valid || !i_stat.full;
    assign o_push     = r_valid && !i_stat.full;
    assign o_item     = r_item;

    always_comb begin
        n_item.mag_x = i_in.vec_x[VEC_W-1] ? VEC_W'(-i_in.vec_x) : VEC_W'(i_in.vec_x);
        n_item.mag_y = i_in.vec_y[VEC_W-1] ? VEC_W'(-i_in.vec_y) : VEC_W'(i_in.vec_y);
        n_item.mag_z = i_in.vec_z[VEC_W-1] ? VEC_W'(-i_in.vec_z) : VEC_W'(i_in.vec_z);
        n_item.neg   = {i_in.vec_z[VEC_W-1], i_in.vec_y[VEC_W-1], i_in.vec_x[VEC_W-1]};
        n_item.zero  = (i_in.vec_x == '0) && (i_in.vec_y == '0) && (i_in.vec_z == '0);
        n_item.sumsq = SUM_W'(n_item.mag_x) * SUM_W'(n_item.mag_x)
                     + SUM_W'(n_item.mag_y) * SUM_W'(n_item.mag_y)
                     + SUM_W'(n_item.mag_z) * SUM_W'(n_item.mag_z);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item <= n_item;
        end
    end

endmodule

// ===== design/qvr_fifo.sv =====
module qvr_fifo import qvr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_push,
    input  t_item      i_item,
    input  logic       i_pop,
    output t_item      o_item,
    output t_fifo_stat o_stat
);

    t_item              r_mem [0:FIFO_DEPTH-1];
    logic [FIFO_AW-1:0] r_wp;
    logic [FIFO_AW-1:0] r_rp;
    logic [FIFO_AW:0]   r_count;

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_count == (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_stat.empty = (r_count == '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= '0;
            r_rp    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            if (i_push && !i_pop) begin
                r_count <= r_count + 1'b1;
            end else if (i_pop && !i_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_stat.full || i_pop))
        else $error("queue written while full");
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_stat.empty)
        else $error("queue read while empty");
`endif

endmodule

// ===== design/qvr_back.sv =====
module qvr_back import qvr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  t_quat      i_quat,
    input  t_item      i_item,
    input  t_fifo_stat i_stat,
    output logic       o_pop,
    qvr_out_if.source  o_out
);

    localparam int DL = SQ_N + 1;
    localparam int M1 = DL + QUO_W + 1;
    localparam int M2 = M1 + 1;
    localparam int M3 = M2 + 1;

    localparam logic signed [PS_W-1:0]  P_HALF  = PS_W'(2**(FRAC_BITS-1));
    localparam logic signed [R_W-1:0]   R_HALF  = R_W'(2**(FRAC_BITS-1));
    localparam logic signed [R_W-1:0]   ROT_MAX = R_W'(2**(ROT_W-1) - 1);
    localparam logic signed [R_W-1:0]   ROT_MIN = -R_W'(2**(ROT_W-1));

    logic en;
    logic [M3:0] r_v;

    logic [RAD_W-1:0] r_rad [0:SQ_N];
    logic [RES_W-1:0] r_res [0:SQ_N];
    logic [RAD_W-1:0] c_rad [1:SQ_N];
    logic [RES_W-1:0] c_res [1:SQ_N];
    logic [VEC_W-1:0] r_mag [0:SQ_N][0:2];
    logic [2:0]       r_neg [0:M1];
    logic             r_zero [0:M3];

    logic [ROOT_W-1:0] r_len [0:QUO_W];
    logic [REM_W-1:0]  r_rem [0:QUO_W][0:2];
    logic [REM_W-1:0]  c_rem [1:QUO_W][0:2];
    logic [QUO_W-1:0]  r_quo [0:QUO_W][0:2];
    logic [QUO_W-1:0]  c_quo [1:QUO_W][0:2];

    logic signed [UNIT_W-1:0] c_u  [0:2];
    logic signed [PR_W-1:0]   r_pr [0:11];
    logic signed [PR_W-1:0]   c_pr [0:11];
    logic signed [PS_W-1:0]   c_ps [0:3];
    logic signed [P_W-1:0]    r_p  [0:3];
    logic signed [MR_W-1:0]   r_mr [0:11];
    logic signed [MR_W-1:0]   c_mr [0:11];
    logic signed [R_W-1:0]    c_r  [0:2];
    logic signed [ROT_W-1:0]  c_rot [0:2];

    logic                    r_ov;
    logic signed [ROT_W-1:0] r_rot [0:2];
    logic                    r_zo;

    assign en    = !r_ov || o_out.ready;
    assign o_pop = en && !i_stat.empty;

    // square root, one result bit per stage
    always_comb begin
        logic [RES_W-1:0] v_bit;
        logic [RES_W-1:0] v_try;
        for (int j = 1; j <= SQ_N; j++) begin
            v_bit = RES_W'(1) << (2 * (SQ_N - j));
            v_try = r_res[j-1] + v_bit;
            if (RES_W'(r_rad[j-1]) >= v_try) begin
                c_rad[j] = r_rad[j-1] - RAD_W'(v_try);
                c_res[j] = (r_res[j-1] >> 1) + v_bit;
            end else begin
                c_rad[j] = r_rad[j-1];
                c_res[j] = r_res[j-1] >> 1;
            end
        end
    end

    // restoring divide, one quotient bit per stage and lane
    always_comb begin
        logic [REM_W-1:0] v_d;
        logic             v_ge;
        for (int s = 1; s <= QUO_W; s++) begin
            for (int k = 0; k < 3; k++) begin
                v_d  = REM_W'(r_len[s-1]) << (QUO_W - s);
                v_ge = (r_rem[s-1][k] >= v_d);
                c_rem[s][k] = v_ge ? (r_rem[s-1][k] - v_d) : r_rem[s-1][k];
                c_quo[s][k] = {r_quo[s-1][k][QUO_W-2:0], v_ge};
            end
        end
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_u[k] = r_neg[M1-1][k] ? -$signed({1'b0, r_quo[QUO_W][k]})
                                    :  $signed({1'b0, r_quo[QUO_W][k]});
        end
        // p = q * (0,u)
        c_pr[0]  = PR_W'(i_quat.x) * PR_W'(c_u[0]);
        c_pr[1]  = PR_W'(i_quat.y) * PR_W'(c_u[1]);
        c_pr[2]  = PR_W'(i_quat.z) * PR_W'(c_u[2]);
        c_pr[3]  = PR_W'(i_quat.w) * PR_W'(c_u[0]);
        c_pr[4]  = PR_W'(i_quat.y) * PR_W'(c_u[2]);
        c_pr[5]  = PR_W'(i_quat.z) * PR_W'(c_u[1]);
        c_pr[6]  = PR_W'(i_quat.w) * PR_W'(c_u[1]);
        c_pr[7]  = PR_W'(i_quat.z) * PR_W'(c_u[0]);
        c_pr[8]  = PR_W'(i_quat.x) * PR_W'(c_u[2]);
        c_pr[9]  = PR_W'(i_quat.w) * PR_W'(c_u[2]);
        c_pr[10] = PR_W'(i_quat.x) * PR_W'(c_u[1]);
        c_pr[11] = PR_W'(i_quat.y) * PR_W'(c_u[0]);
    end

    always_comb begin
        c_ps[0] = -PS_W'(r_pr[0]) - PS_W'(r_pr[1]) - PS_W'(r_pr[2]);
        c_ps[1] =  PS_W'(r_pr[3]) + PS_W'(r_pr[4]) - PS_W'(r_pr[5]);
        c_ps[2] =  PS_W'(r_pr[6]) + PS_W'(r_pr[7]) - PS_W'(r_pr[8]);
        c_ps[3] =  PS_W'(r_pr[9]) + PS_W'(r_pr[10]) - PS_W'(r_pr[11]);
    end

    // r = p * conj(q), vector part
    always_comb begin
        c_mr[0]  = MR_W'(r_p[0]) * MR_W'(i_quat.x);
        c_mr[1]  = MR_W'(r_p[1]) * MR_W'(i_quat.w);
        c_mr[2]  = MR_W'(r_p[2]) * MR_W'(i_quat.z);
        c_mr[3]  = MR_W'(r_p[3]) * MR_W'(i_quat.y);
        c_mr[4]  = MR_W'(r_p[0]) * MR_W'(i_quat.y);
        c_mr[5]  = MR_W'(r_p[2]) * MR_W'(i_quat.w);
        c_mr[6]  = MR_W'(r_p[3]) * MR_W'(i_quat.x);
        c_mr[7]  = MR_W'(r_p[1]) * MR_W'(i_quat.z);
        c_mr[8]  = MR_W'(r_p[0]) * MR_W'(i_quat.z);
        c_mr[9]  = MR_W'(r_p[3]) * MR_W'(i_quat.w);
        c_mr[10] = MR_W'(r_p[1]) * MR_W'(i_quat.y);
        c_mr[11] = MR_W'(r_p[2]) * MR_W'(i_quat.x);
    end

    always_comb begin
        for (int k = 0; k < 3; k++) begin
            c_r[k] = -R_W'(r_mr[4*k]) + R_W'(r_mr[4*k+1])
                   -  R_W'(r_mr[4*k+2]) + R_W'(r_mr[4*k+3]) + R_HALF;
            c_r[k] = c_r[k] >>> FRAC_BITS;
            if (r_zero[M3]) begin
                c_rot[k] = '0;
            end else if (c_r[k] > ROT_MAX) begin
                c_rot[k] = ROT_MAX[ROT_W-1:0];
            end else if (c_r[k] < ROT_MIN) begin
                c_rot[k] = ROT_MIN[ROT_W-1:0];
            end else begin
                c_rot[k] = c_r[k][ROT_W-1:0];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v  <= '0;
            r_ov <= 1'b0;
        end else if (en) begin
            r_v[0] <= o_pop;
            for (int s = 1; s <= M3; s++) begin
                r_v[s] <= r_v[s-1];
            end
            r_ov <= r_v[M3];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_rad[0]    <= RAD_W'(i_item.sumsq) << SQ_PAD;
            r_res[0]    <= '0;
            r_mag[0][0] <= i_item.mag_x;
            r_mag[0][1] <= i_item.mag_y;
            r_mag[0][2] <= i_item.mag_z;
            r_neg[0]    <= i_item.neg;
            r_zero[0]   <= i_item.zero;
            for (int j = 1; j <= SQ_N; j++) begin
                r_rad[j] <= c_rad[j];
                r_res[j] <= c_res[j];
                r_mag[j] <= r_mag[j-1];
            end
            for (int s = 1; s <= M1; s++) begin
                r_neg[s] <= r_neg[s-1];
            end
            for (int s = 1; s <= M3; s++) begin
                r_zero[s] <= r_zero[s-1];
            end
            r_len[0] <= r_res[SQ_N][ROOT_W-1:0];
            for (int k = 0; k < 3; k++) begin
                // round half up: add half the length before dividing
                r_rem[0][k] <= (REM_W'(r_mag[SQ_N][k]) << (FRAC_BITS + LEN_FRAC))
                             + REM_W'(r_res[SQ_N][ROOT_W-1:1]);
                r_quo[0][k] <= '0;
            end
            for (int s = 1; s <= QUO_W; s++) begin
                r_len[s] <= r_len[s-1];
                r_rem[s] <= c_rem[s];
                r_quo[s] <= c_quo[s];
            end
            r_pr <= c_pr;
            for (int k = 0; k < 4; k++) begin
                r_p[k] <= P_W'((c_ps[k] + P_HALF) >>> FRAC_BITS);
            end
            r_mr  <= c_mr;
            r_rot <= c_rot;
            r_zo  <= r_zero[M3];
        end
    end

    assign o_out.valid      = r_ov;
    assign o_out.rot_x      = r_rot[0];
    assign o_out.rot_y      = r_rot[1];
    assign o_out.rot_z      = r_rot[2];
    assign o_out.zero_input = r_zo;

`ifndef SYNTHESIS
    a_zero_passes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_ov && r_zo) |-> (r_rot[0] == '0 && r_rot[1] == '0 && r_rot[2] == '0))
        else $error("zero vector gave a nonzero result");
    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !en |=> $stable(r_v))
        else $error("pipeline moved during stall");
`endif

endmodule

// ===== sim/tb.sv =====
module tb;
    import qvr_pkg::*;

    typedef struct {
        logic signed [VEC_W-1:0] vx;
        logic signed [VEC_W-1:0] vy;
        logic signed [VEC_W-1:0] vz;
    } t_vec;

    typedef struct {
        logic signed [ROT_W-1:0] rx;
        logic signed [ROT_W-1:0] ry;
        logic signed [ROT_W-1:0] rz;
        logic                    zero;
    } t_rot;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic              i_psel = 1'b0;
    logic              i_penable = 1'b0;
    logic              i_pwrite = 1'b0;
    logic [ADDR_W-1:0] i_paddr = '0;
    logic [DATA_W-1:0] i_pwdata = '0;
    logic [DATA_W-1:0] o_prdata;
    logic              o_pready;

    qvr_in_if  in_ch();
    qvr_out_if out_ch();

    quaternion_vector_rotation dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch.sink), .o_out(out_ch.source),
        .i_psel(i_psel), .i_penable(i_penable), .i_pwrite(i_pwrite),
        .i_paddr(i_paddr), .i_pwdata(i_pwdata), .o_prdata(o_prdata),
        .o_pready(o_pready)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // quaternion copy used for prediction
    longint qw = 16384, qx = 0, qy = 0, qz = 0;

    t_vec pending_vecs[$];
    t_rot expected_rots[$];
    int   errors = 0;
    bit   stim_done = 0;
    bit   calm = 0;  // no idling on either side
    bit   in_acc = 0;  // input beat taken at the last rising edge

    function automatic longint round_q(longint v);
        return (v + (longint'(1) << (FRAC_BITS - 1))) >>> FRAC_BITS;
    endfunction

    function automatic logic signed [ROT_W-1:0] clamp_rot(longint v);
        if (v > 65535) v = 65535;
        if (v < -65536) v = -65536;
        return v[ROT_W-1:0];
    endfunction

    function automatic longint to_unit(longint c, longint len);
        longint m, q;
        m = c < 0 ? -c : c;
        q = ((m << (FRAC_BITS + 8)) + (len >> 1)) / len;
        return c < 0 ? -q : q;
    endfunction

    function automatic t_rot rotate_vec(t_vec v);
        t_rot r;
        longint vx, vy, vz, ux, uy, uz, pw, px, py, pz;
        longint unsigned sq, root, b;
        vx = v.vx; vy = v.vy; vz = v.vz;
        r.zero = 0;
        if (vx == 0 && vy == 0 && vz == 0) begin
            r.rx = 0; r.ry = 0; r.rz = 0; r.zero = 1;
            return r;
        end
        sq = (vx * vx + vy * vy + vz * vz) << 16;
        root = 0;
        b = 64'd1 << 62;
        while (b > sq) b >>= 2;
        while (b != 0) begin
            if (sq >= root + b) begin
                sq -= root + b;
                root = (root >> 1) + b;
            end else begin
                root >>= 1;
            end
            b >>= 2;
        end
        ux = to_unit(vx, root);
        uy = to_unit(vy, root);
        uz = to_unit(vz, root);
        pw = round_q(-qx * ux - qy * uy - qz * uz);
        px = round_q(qw * ux + qy * uz - qz * uy);
        py = round_q(qw * uy + qz * ux - qx * uz);
        pz = round_q(qw * uz + qx * uy - qy * ux);
        r.rx = clamp_rot(round_q(-pw * qx + px * qw - py * qz + pz * qy));
        r.ry = clamp_rot(round_q(-pw * qy + py * qw - pz * qx + px * qz));
        r.rz = clamp_rot(round_q(-pw * qz + pz * qw - px * qy + py * qx));
        return r;
    endfunction

    // driver
    initial begin
        in_ch.valid = 1'b0;
        in_ch.vec_x = '0;
        in_ch.vec_y = '0;
        in_ch.vec_z = '0;
        out_ch.ready = 1'b0;
    end

    always @(negedge i_clk) begin
        if (i_rst_n) begin
            // advance only once the held beat was taken
            if (!in_ch.valid || in_acc) begin
                if (pending_vecs.size() != 0 && (calm || $urandom_range(99) >= 13)) begin
                    in_ch.valid <= 1'b1;
                    in_ch.vec_x <= pending_vecs[0].vx;
                    in_ch.vec_y <= pending_vecs[0].vy;
                    in_ch.vec_z <= pending_vecs[0].vz;
                end else begin
                    in_ch.valid <= 1'b0;
                end
            end
            out_ch.ready <= calm || $urandom_range(99) >= 13;
        end
    end

    // accept input beats and predict
    always @(posedge i_clk) begin
        in_acc = i_rst_n && in_ch.valid && in_ch.ready;
        if (in_acc) begin
            expected_rots.push_back(rotate_vec(pending_vecs.pop_front()));
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_rot want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (expected_rots.size() == 0) begin
                $error("unexpected result beat");
                errors++;
            end else begin
                want = expected_rots.pop_front();
                if (out_ch.rot_x !== want.rx) begin
                    $error("rot_x exp %0d got %0d", want.rx, out_ch.rot_x); errors++;
                end
                if (out_ch.rot_y !== want.ry) begin
                    $error("rot_y exp %0d got %0d", want.ry, out_ch.rot_y); errors++;
                end
                if (out_ch.rot_z !== want.rz) begin
                    $error("rot_z exp %0d got %0d", want.rz, out_ch.rot_z); errors++;
                end
                if (out_ch.zero_input !== want.zero) begin
                    $error("zero_input exp %0d got %0d", want.zero, out_ch.zero_input);
                    errors++;
                end
            end
        end
    end

    task automatic push_vec(int x, int y, int z);
        t_vec v;
        v.vx = x; v.vy = y; v.vz = z;
        pending_vecs.push_back(v);
    endtask

    task automatic drain();
        while (pending_vecs.size() != 0 || in_ch.valid || expected_rots.size() != 0)
            @(posedge i_clk);
    endtask

    task automatic write_quat(t_reg_idx idx, int val);
        @(negedge i_clk);
        i_psel <= 1'b1;
        i_pwrite <= 1'b1;
        i_paddr <= ADDR_W'(idx) << 2;
        i_pwdata <= DATA_W'(val);
        @(negedge i_clk);
        i_penable <= 1'b1;
        @(negedge i_clk);
        i_psel <= 1'b0;
        i_penable <= 1'b0;
        i_pwrite <= 1'b0;
        case (idx)
            REG_QUAT_W: qw = longint'(signed'(16'(val)));
            REG_QUAT_X: qx = longint'(signed'(16'(val)));
            REG_QUAT_Y: qy = longint'(signed'(16'(val)));
            default:    qz = longint'(signed'(16'(val)));
        endcase
    endtask

    task automatic set_quat(int w, int x, int y, int z);
        write_quat(REG_QUAT_W, w);
        write_quat(REG_QUAT_X, x);
        write_quat(REG_QUAT_Y, y);
        write_quat(REG_QUAT_Z, z);
    endtask

    task automatic random_vec();
        int k;
        k = $urandom_range(9);
        if (k == 0) push_vec(0, 0, 0);
        else if (k < 3)
            push_vec($urandom_range(15) - 8, $urandom_range(15) - 8, $urandom_range(15) - 8);
        else
            push_vec($urandom_range(65535) - 32768, $urandom_range(65535) - 32768,
                     $urandom_range(65535) - 32768);
    endtask

    initial begin
        int phase;
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // directed: reset quaternion is identity
        push_vec(0, 0, 0);
        push_vec(32767, 0, 0);
        push_vec(-32768, 0, 0);
        push_vec(0, -32768, 0);
        push_vec(0, 0, 32767);
        push_vec(-32768, -32768, -32768);
        push_vec(32767, 32767, 32767);
        push_vec(1, 0, 0);
        push_vec(-1, 1, -1);
        push_vec(3, -4, 12);
        push_vec(32767, -32768, 1);
        drain();
        repeat (60) @(posedge i_clk);

        // 90 degrees about z, then a non-unit, full-scale quaternion
        set_quat(11585, 0, 0, 11585);
        push_vec(1, 0, 0); push_vec(0, 1, 0); push_vec(0, 0, -5); push_vec(0, 0, 0);
        drain();
        repeat (60) @(posedge i_clk);
        set_quat(-32768, 32767, -32768, 32767);
        push_vec(1, 1, 1); push_vec(-32768, 5, 7); push_vec(0, 0, 0); push_vec(100, -3, 0);
        drain();
        repeat (60) @(posedge i_clk);

        for (phase = 0; phase < 6; phase++) begin
            case (phase)
                0: set_quat(16384, 0, 0, 0);
                1: set_quat(-16384, 16384, -16384, 16384);
                2: set_quat(0, 16384, 0, 0);
                default: set_quat($urandom_range(65535), $urandom_range(65535),
                                  $urandom_range(65535), $urandom_range(65535));
            endcase
            if (phase == 4) set_quat(8192, 8192, -8192, 8192);
            calm = (phase == 2);
            repeat (200) random_vec();
            if (phase == 1) begin
                // hold input until the pipeline runs dry
                while (pending_vecs.size() != 0) @(posedge i_clk);
                drain();
                repeat (20) random_vec();
            end
            drain();
            repeat (60) @(posedge i_clk);
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (errors == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

    initial begin
        #2000000;
        $display("tb: done, errors");
        $finish;
    end
endmodule
